// File: rtl/pclip_pkg.sv
// ----------------------------------------------------------------------------
// pclip_pkg
// Shared widths, types and register codes of the polygon plane clipper.
// ----------------------------------------------------------------------------
package pclip_pkg;

  localparam int CoordW   = 32;
  localparam int NormW    = 16;
  localparam int TFrac    = 16;
  localparam int NumComp  = 8;
  localparam int DistW    = CoordW + NormW + 4;
  localparam int DataW    = 5 * CoordW + 3 * NormW;
  localparam int DataBytesW = ((DataW + 7) / 8) * 8;

  // Every component is held sign extended to CoordW bits:
  // 0..2 position, 3..5 normal, 6..7 texture coordinate.
  typedef logic [NumComp-1:0][CoordW-1:0] vtx_t;

  localparam logic [1:0] RegNormX  = 2'd0;
  localparam logic [1:0] RegNormY  = 2'd1;
  localparam logic [1:0] RegNormZ  = 2'd2;
  localparam logic [1:0] RegOffset = 2'd3;

endpackage

// File: rtl/polygon_plane_clipper_top.sv
// ----------------------------------------------------------------------------
// polygon_plane_clipper_top
// Clips a streamed polygon against the half-space n.p <= d.
//
// Channel  Direction  Handshake              Word
// s_axis   in         tvalid/tready          vertex, tlast = last vertex
// m_axis   out        tvalid/tready          vertex, tuser = valid, tlast = end
// apb      in         psel/penable/pready    plane normal and offset
//
// A vertex is taken only while the block is idle. Each edge takes two
// distance passes, and a crossing edge also runs the serial divider and
// the serial interpolator. Reset clears control state and loads the plane
// y <= 0; vertex data registers are not reset. A stalled output holds the
// sequencer in its push or flush step.
// ----------------------------------------------------------------------------
module polygon_plane_clipper_top (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  // pos_x, pos_y, pos_z, norm_x, norm_y, norm_z, tex_u, tex_v
  input  logic [pclip_pkg::DataBytesW-1:0]   s_axis_tdata_i,
  input  logic                               s_axis_tlast_i,
  output logic                               m_axis_tvalid_o,
  input  logic                               m_axis_tready_i,
  // out_pos_x, out_pos_y, out_pos_z, out_norm_x, out_norm_y, out_norm_z,
  // out_tex_u, out_tex_v
  output logic [pclip_pkg::DataBytesW-1:0]   m_axis_tdata_o,
  // vertex_valid
  output logic                               m_axis_tuser_o,
  output logic                               m_axis_tlast_o,
  input  logic                               psel_i,
  input  logic                               penable_i,
  input  logic                               pwrite_i,
  input  logic [3:0]                         paddr_i,
  input  logic [31:0]                        pwdata_i,
  output logic [31:0]                        prdata_o,
  output logic                               pready_o
);

  localparam int CW = pclip_pkg::CoordW;
  localparam int NW = pclip_pkg::NormW;
  localparam int DW = pclip_pkg::DistW;
  localparam int PW = CW + NW;

  typedef enum logic [3:0] {
    ST_IDLE, ST_DA, ST_DB, ST_TEST, ST_DIV, ST_LERP, ST_PUSH, ST_NEXT, ST_FLUSH
  } state_e;

  state_e                         state_q;
  logic [2:0][NW-1:0]             norm_q;
  logic [CW-1:0]                  offset_q;
  logic                           expect_first_q;
  logic                           last_q;
  logic                           second_q;
  logic                           cross_q;
  logic                           from_a_q;
  pclip_pkg::vtx_t                first_q;
  pclip_pkg::vtx_t                prev_q;
  pclip_pkg::vtx_t                cur_q;
  pclip_pkg::vtx_t                ea_q;
  pclip_pkg::vtx_t                eb_q;
  pclip_pkg::vtx_t                prod_q;
  pclip_pkg::vtx_t                pend_q;
  logic                           pend_valid_q;
  pclip_pkg::vtx_t                out_q;
  logic                           out_valid_q;
  logic                           out_vv_q;
  logic                           out_end_q;
  logic [1:0]                     dcnt_q;
  logic signed [DW-1:0]           dacc_q;
  logic signed [DW-1:0]           da_q;
  logic signed [DW-1:0]           db_q;
  logic                           div_start_q;
  logic                           lerp_start_q;

  pclip_pkg::vtx_t                vin;
  pclip_pkg::vtx_t                dv;
  logic signed [PW-1:0]           prod;
  logic signed [DW-1:0]           dsum;
  logic signed [DW-1:0]           dinit;
  logic                           out_free;
  logic                           ina;
  logic                           inb;
  logic                           div_done;
  logic [pclip_pkg::TFrac:0]      t_val;
  logic                           lerp_done;
  pclip_pkg::vtx_t                lerp_c;
  logic                           cfg_wr;
  logic [1:0]                     cfg_idx;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      vin[i]     = s_axis_tdata_i[i*CW +: CW];
      vin[3 + i] = {{(CW-NW){s_axis_tdata_i[3*CW + i*NW + NW-1]}},
                    s_axis_tdata_i[3*CW + i*NW +: NW]};
    end
    vin[6] = s_axis_tdata_i[3*CW + 3*NW +: CW];
    vin[7] = s_axis_tdata_i[4*CW + 3*NW +: CW];
  end

  assign dv    = (state_q == ST_DB) ? eb_q : ea_q;
  assign prod  = $signed(norm_q[dcnt_q]) * $signed(dv[{1'b0, dcnt_q}]);
  assign dsum  = dacc_q + {{(DW-PW+2){prod[PW-1]}}, prod[PW-1:2]};
  assign dinit = 0 - {{(DW-CW-12){offset_q[CW-1]}}, offset_q, 12'b0};
  assign ina   = da_q[DW-1] || (da_q == '0);
  assign inb   = db_q[DW-1] || (db_q == '0);
  assign out_free = !out_valid_q || m_axis_tready_i;

  assign cfg_wr  = psel_i && penable_i && pwrite_i;
  assign cfg_idx = paddr_i[3:2];

  pclip_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start_q),
    .da_i    (da_q),
    .db_i    (db_q),
    .done_o  (div_done),
    .t_o     (t_val)
  );

  pclip_lerp u_lerp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (lerp_start_q),
    .a_i     (ea_q),
    .b_i     (eb_q),
    .t_i     (t_val),
    .done_o  (lerp_done),
    .c_o     (lerp_c)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      norm_q[0]      <= '0;
      norm_q[1]      <= NW'(16384);
      norm_q[2]      <= '0;
      offset_q       <= '0;
      expect_first_q <= 1'b1;
      pend_valid_q   <= 1'b0;
      out_valid_q    <= 1'b0;
      div_start_q    <= 1'b0;
      lerp_start_q   <= 1'b0;
      dcnt_q         <= '0;
    end else begin
      div_start_q  <= 1'b0;
      lerp_start_q <= 1'b0;
      if (out_valid_q && m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_wr) begin
        unique case (cfg_idx)
          pclip_pkg::RegNormX:  norm_q[0] <= pwdata_i[NW-1:0];
          pclip_pkg::RegNormY:  norm_q[1] <= pwdata_i[NW-1:0];
          pclip_pkg::RegNormZ:  norm_q[2] <= pwdata_i[NW-1:0];
          pclip_pkg::RegOffset: offset_q  <= pwdata_i[CW-1:0];
          default: ;
        endcase
      end
      unique case (state_q)
        ST_IDLE: begin
          if (s_axis_tvalid_i) begin
            last_q <= s_axis_tlast_i;
            cur_q  <= vin;
            prev_q <= vin;
            eb_q   <= vin;
            dacc_q <= dinit;
            dcnt_q <= '0;
            if (expect_first_q) begin
              first_q        <= vin;
              ea_q           <= vin;
              second_q       <= 1'b0;
              expect_first_q <= 1'b0;
              if (s_axis_tlast_i) begin
                state_q <= ST_DA;
              end
            end else begin
              ea_q     <= prev_q;
              second_q <= s_axis_tlast_i;
              state_q  <= ST_DA;
            end
          end
        end
        ST_DA, ST_DB: begin
          dacc_q <= dsum;
          dcnt_q <= dcnt_q + 1'b1;
          if (dcnt_q == 2'd2) begin
            dacc_q <= dinit;
            dcnt_q <= '0;
            if (state_q == ST_DA) begin
              da_q    <= dsum;
              state_q <= ST_DB;
            end else begin
              db_q    <= dsum;
              state_q <= ST_TEST;
            end
          end
        end
        ST_TEST: begin
          cross_q <= ina != inb;
          if (ina) begin
            prod_q   <= ea_q;
            from_a_q <= 1'b1;
            state_q  <= ST_PUSH;
          end else if (ina != inb) begin
            div_start_q <= 1'b1;
            state_q     <= ST_DIV;
          end else begin
            state_q <= ST_NEXT;
          end
        end
        ST_DIV: begin
          if (div_done) begin
            lerp_start_q <= 1'b1;
            state_q      <= ST_LERP;
          end
        end
        ST_LERP: begin
          if (lerp_done) begin
            prod_q   <= lerp_c;
            from_a_q <= 1'b0;
            state_q  <= ST_PUSH;
          end
        end
        ST_PUSH: begin
          if (!pend_valid_q || out_free) begin
            if (pend_valid_q) begin
              out_q       <= pend_q;
              out_vv_q    <= 1'b1;
              out_end_q   <= 1'b0;
              out_valid_q <= 1'b1;
            end
            pend_q       <= prod_q;
            pend_valid_q <= 1'b1;
            if (from_a_q && cross_q) begin
              div_start_q <= 1'b1;
              state_q     <= ST_DIV;
            end else begin
              state_q <= ST_NEXT;
            end
          end
        end
        ST_NEXT: begin
          if (second_q) begin
            second_q <= 1'b0;
            ea_q     <= cur_q;
            eb_q     <= first_q;
            state_q  <= ST_DA;
          end else begin
            state_q <= ST_FLUSH;
          end
        end
        ST_FLUSH: begin
          if (!last_q && !pend_valid_q) begin
            state_q <= ST_IDLE;
          end else if (out_free) begin
            out_q          <= pend_valid_q ? pend_q : '0;
            out_vv_q       <= pend_valid_q;
            out_end_q      <= last_q;
            out_valid_q    <= 1'b1;
            pend_valid_q   <= 1'b0;
            expect_first_q <= last_q;
            state_q        <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  always_comb begin
    m_axis_tdata_o = '0;
    for (int i = 0; i < 3; i++) begin
      m_axis_tdata_o[i*CW +: CW]        = out_q[i];
      m_axis_tdata_o[3*CW + i*NW +: NW] = out_q[3 + i][NW-1:0];
    end
    m_axis_tdata_o[3*CW + 3*NW +: CW] = out_q[6];
    m_axis_tdata_o[4*CW + 3*NW +: CW] = out_q[7];
  end

  always_comb begin
    unique case (cfg_idx)
      pclip_pkg::RegNormX:  prdata_o = {16'b0, norm_q[0]};
      pclip_pkg::RegNormY:  prdata_o = {16'b0, norm_q[1]};
      pclip_pkg::RegNormZ:  prdata_o = {16'b0, norm_q[2]};
      pclip_pkg::RegOffset: prdata_o = offset_q;
      default:              prdata_o = '0;
    endcase
  end

  assign s_axis_tready_o = state_q == ST_IDLE;
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = out_vv_q;
  assign m_axis_tlast_o  = out_end_q;
  assign pready_o        = 1'b1;

endmodule

// File: rtl/pclip_div.sv
// ----------------------------------------------------------------------------
// pclip_div
// Bit-serial restoring divider: t = floor(|da| * 2^TFrac / (|da| + |db|)),
// one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pclip_div (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  start_i,
  input  logic signed [pclip_pkg::DistW-1:0]    da_i,
  input  logic signed [pclip_pkg::DistW-1:0]    db_i,
  output logic                                  done_o,
  output logic        [pclip_pkg::TFrac:0]      t_o
);

  localparam int CntW = $clog2(pclip_pkg::TFrac + 1);
  localparam int RemW = pclip_pkg::DistW + 2;

  logic                           busy_q;
  logic [CntW-1:0]                cnt_q;
  logic [RemW-1:0]                rem_q;
  logic [pclip_pkg::DistW:0]      den_q;
  logic [pclip_pkg::TFrac:0]      quo_q;
  logic                           done_q;
  logic [pclip_pkg::DistW-1:0]    mag_a;
  logic [pclip_pkg::DistW-1:0]    mag_b;
  logic [RemW-1:0]                trial;
  logic                           take;

  assign mag_a = da_i[pclip_pkg::DistW-1] ? 0 - da_i : da_i;
  assign mag_b = db_i[pclip_pkg::DistW-1] ? 0 - db_i : db_i;
  assign trial = (cnt_q == '0) ? rem_q : {rem_q[RemW-2:0], 1'b0};
  assign take  = trial >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
        rem_q  <= {2'b00, mag_a};
        den_q  <= {1'b0, mag_a} + {1'b0, mag_b};
        quo_q  <= '0;
      end else if (busy_q) begin
        rem_q <= take ? trial - {1'b0, den_q} : trial;
        quo_q <= {quo_q[pclip_pkg::TFrac-1:0], take};
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CntW'(pclip_pkg::TFrac)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o = done_q;
  assign t_o    = quo_q;

endmodule

// File: rtl/pclip_lerp.sv
// ----------------------------------------------------------------------------
// pclip_lerp
// Eight-lane interpolator: c = a + floor((b - a) * t / 2^TFrac), with t
// shifted in one bit per cycle, most significant bit first.
// ----------------------------------------------------------------------------
module pclip_lerp (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  pclip_pkg::vtx_t                a_i,
  input  pclip_pkg::vtx_t                b_i,
  input  logic [pclip_pkg::TFrac:0]      t_i,
  output logic                           done_o,
  output pclip_pkg::vtx_t                c_o
);

  localparam int CntW  = $clog2(pclip_pkg::TFrac + 1);
  localparam int DiffW = pclip_pkg::CoordW + 1;
  localparam int AccW  = DiffW + pclip_pkg::TFrac + 2;

  logic                                        busy_q;
  logic                                        done_q;
  logic [CntW-1:0]                             cnt_q;
  logic [pclip_pkg::TFrac:0]                   t_q;
  pclip_pkg::vtx_t                             a_q;
  pclip_pkg::vtx_t                             c_q;
  logic [pclip_pkg::NumComp-1:0][DiffW-1:0]    diff_q;
  logic [pclip_pkg::NumComp-1:0][AccW-1:0]     acc_q;
  logic [pclip_pkg::NumComp-1:0][AccW-1:0]     acc_d;

  always_comb begin
    for (int i = 0; i < pclip_pkg::NumComp; i++) begin
      acc_d[i] = {acc_q[i][AccW-2:0], 1'b0}
               + (t_q[pclip_pkg::TFrac]
                  ? {{(AccW-DiffW){diff_q[i][DiffW-1]}}, diff_q[i]} : '0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
        t_q    <= t_i;
        a_q    <= a_i;
        for (int i = 0; i < pclip_pkg::NumComp; i++) begin
          diff_q[i] <= {b_i[i][pclip_pkg::CoordW-1], b_i[i]}
                     - {a_i[i][pclip_pkg::CoordW-1], a_i[i]};
          acc_q[i]  <= '0;
        end
      end else if (busy_q) begin
        t_q   <= {t_q[pclip_pkg::TFrac-1:0], 1'b0};
        cnt_q <= cnt_q + 1'b1;
        acc_q <= acc_d;
        if (cnt_q == CntW'(pclip_pkg::TFrac)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
          for (int i = 0; i < pclip_pkg::NumComp; i++) begin
            c_q[i] <= a_q[i] + acc_d[i][pclip_pkg::TFrac +: pclip_pkg::CoordW];
          end
        end
      end
    end
  end

  assign done_o = done_q;
  assign c_o    = c_q;

endmodule

// File: tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking testbench of the polygon plane clipper.
// Polygons of random size stream in while both sides idle and stall at random.
// An internal model of the clipper works out the vertices each word should
// produce, and every output word is compared with the oldest expected one.
// The plane registers are rewritten between phases, extremes included.
// ----------------------------------------------------------------------------
module tb;

  typedef struct {
    logic signed [31:0] p[3];
    logic signed [15:0] n[3];
    logic signed [31:0] uv[2];
  } vert_t;

  typedef struct {
    logic [pclip_pkg::DataBytesW-1:0] data;
    logic                             vld;
    logic                             fin;
  } outw_t;

  typedef struct {
    vert_t v;
    logic  last;
    logic  has_exp;
    outw_t exp_w;
  } row_t;

  logic clk_i = 0;
  logic rst_ni = 0;
  logic s_axis_tvalid_i = 0;
  logic s_axis_tready_o;
  logic [pclip_pkg::DataBytesW-1:0] s_axis_tdata_i = '0;
  logic s_axis_tlast_i = 0;
  logic m_axis_tvalid_o;
  logic m_axis_tready_i = 0;
  logic [pclip_pkg::DataBytesW-1:0] m_axis_tdata_o;
  logic m_axis_tuser_o;
  logic m_axis_tlast_o;
  logic psel_i = 0, penable_i = 0, pwrite_i = 0;
  logic [3:0] paddr_i = '0;
  logic [31:0] pwdata_i = '0;
  logic [31:0] prdata_o;
  logic pready_o;

  polygon_plane_clipper_top u_top (.*);

  always #5 clk_i = ~clk_i;

  logic signed [15:0] pl_nx = 0, pl_ny = 16384, pl_nz = 0;
  logic signed [31:0] pl_off = 0;
  logic  poly_open = 0;
  vert_t first_v, prev_v;
  outw_t clip_q[$];
  int    errors = 0;
  longint cycles = 0;
  bit    stim_done = 0;
  bit    hold_off = 0;

  function automatic logic [pclip_pkg::DataBytesW-1:0] pack_vert(vert_t v);
    logic [pclip_pkg::DataBytesW-1:0] d;
    d = '0;
    d[31:0] = v.p[0]; d[63:32] = v.p[1]; d[95:64] = v.p[2];
    d[111:96] = v.n[0]; d[127:112] = v.n[1]; d[143:128] = v.n[2];
    d[175:144] = v.uv[0]; d[207:176] = v.uv[1];
    return d;
  endfunction

  function automatic longint fdiv4(longint x);
    return x >>> 2;
  endfunction

  function automatic longint plane_dist(vert_t v);
    return fdiv4(longint'(pl_nx) * v.p[0]) + fdiv4(longint'(pl_ny) * v.p[1])
         + fdiv4(longint'(pl_nz) * v.p[2]) - longint'(pl_off) * 4096;
  endfunction

  function automatic longint lerp(longint a, longint b, longint t);
    longint diff, lo, hi;
    diff = b - a;
    lo = diff & 64'hFF_FFFF;
    hi = (diff - lo) >>> 24;
    return a + hi * t * 256 + ((lo * t) >>> pclip_pkg::TFrac);
  endfunction

  function automatic longint ratio(longint ma, longint mb);
    longint r, den, q;
    r = ma;
    den = ma + mb;
    q = 0;
    if (r >= den) begin
      q = 1;
      r = r - den;
    end
    for (int i = 0; i < pclip_pkg::TFrac; i++) begin
      r = r <<< 1;
      q = q <<< 1;
      if (r >= den) begin
        q = q | 1;
        r = r - den;
      end
    end
    return q;
  endfunction

  function automatic vert_t cross_point(vert_t a, vert_t b, longint da, longint db);
    longint ma, mb, t;
    vert_t c;
    ma = da < 0 ? -da : da;
    mb = db < 0 ? -db : db;
    t = ratio(ma, mb);
    for (int i = 0; i < 3; i++) begin
      c.p[i] = 32'(lerp(a.p[i], b.p[i], t));
      c.n[i] = 16'(lerp(a.n[i], b.n[i], t));
    end
    for (int i = 0; i < 2; i++) c.uv[i] = 32'(lerp(a.uv[i], b.uv[i], t));
    return c;
  endfunction

  task automatic clip_edge(vert_t a, vert_t b, ref outw_t ws[$]);
    longint da, db;
    outw_t w;
    da = plane_dist(a);
    db = plane_dist(b);
    w.vld = 1; w.fin = 0;
    if (da <= 0) begin
      w.data = pack_vert(a);
      ws = {ws, w};
    end
    if ((da <= 0) != (db <= 0)) begin
      w.data = pack_vert(cross_point(a, b, da, db));
      ws = {ws, w};
    end
  endtask

  task automatic predict_clip(vert_t v, logic last);
    outw_t ws[$];
    outw_t w;
    if (!poly_open) begin
      first_v = v; prev_v = v; poly_open = 1;
      if (last) clip_edge(v, v, ws);
    end else begin
      clip_edge(prev_v, v, ws);
      prev_v = v;
      if (last) clip_edge(v, first_v, ws);
    end
    if (last) begin
      if (ws.size() == 0) begin
        w.data = '0; w.vld = 0; w.fin = 0;
        ws = {ws, w};
      end
      ws[ws.size()-1].fin = 1;
      poly_open = 0;
    end
    clip_q = {clip_q, ws};
  endtask

  task automatic apb_write(logic [1:0] idx, logic [31:0] val);
    @(negedge clk_i);
    psel_i <= 1; pwrite_i <= 1; penable_i <= 0;
    paddr_i <= {idx, 2'b00}; pwdata_i <= val;
    @(negedge clk_i);
    penable_i <= 1;
    @(negedge clk_i);
    psel_i <= 0; penable_i <= 0; pwrite_i <= 0;
    case (idx)
      pclip_pkg::RegNormX:  pl_nx = val[15:0];
      pclip_pkg::RegNormY:  pl_ny = val[15:0];
      pclip_pkg::RegNormZ:  pl_nz = val[15:0];
      pclip_pkg::RegOffset: pl_off = val;
      default: ;
    endcase
  endtask

  task automatic stop_in();
    s_axis_tvalid_i <= 0;
    @(negedge clk_i);
  endtask

  task automatic set_plane(logic [15:0] nx, logic [15:0] ny, logic [15:0] nz,
                           logic [31:0] off);
    stop_in();
    while (clip_q.size() != 0) @(negedge clk_i);
    repeat (120) @(negedge clk_i);
    apb_write(pclip_pkg::RegNormX, {16'h0, nx});
    apb_write(pclip_pkg::RegNormY, {16'h0, ny});
    apb_write(pclip_pkg::RegNormZ, {16'h0, nz});
    apb_write(pclip_pkg::RegOffset, off);
  endtask

  task automatic send_vert(vert_t v, logic last);
    int gap;
    gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      s_axis_tvalid_i <= 0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tdata_i <= pack_vert(v);
    s_axis_tlast_i <= last;
    s_axis_tvalid_i <= 1;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    predict_clip(v, last);
    @(negedge clk_i);
  endtask

  function automatic logic [31:0] rnd_coord(int mode);
    case (mode)
      0: return $urandom();
      1: return 32'($signed($urandom_range(0, 40 << 16)) - (20 << 16));
      default: return 32'($signed($urandom_range(0, 2000)) - 1000) <<< 16;
    endcase
  endfunction

  function automatic vert_t rnd_vert(int mode);
    vert_t v;
    for (int i = 0; i < 3; i++) begin
      v.p[i] = rnd_coord(mode);
      v.n[i] = 16'($urandom());
    end
    v.uv[0] = $urandom(); v.uv[1] = $urandom();
    return v;
  endfunction

  function automatic vert_t fill_vert(logic [31:0] c, logic [15:0] n);
    vert_t v;
    for (int i = 0; i < 3; i++) begin
      v.p[i] = c; v.n[i] = n;
    end
    v.uv[0] = c; v.uv[1] = ~c;
    return v;
  endfunction

  initial begin
    row_t rows[$];
    row_t r;
    vert_t v;
    int nv, mode;
    repeat (10) @(negedge clk_i);
    rst_ni <= 1;
    @(negedge clk_i);
    // Reset plane is y <= 0: single vertices on each side and on it, with exact results.
    r.v = fill_vert(32'h8000_0000, 16'h7FFF); r.last = 1; r.has_exp = 1;
    r.exp_w.data = pack_vert(r.v); r.exp_w.vld = 1; r.exp_w.fin = 1;
    rows = {rows, r};
    r.v = fill_vert(32'h7FFF_FFFF, 16'h8000); r.has_exp = 1;
    r.exp_w.data = '0; r.exp_w.vld = 0; r.exp_w.fin = 1;
    rows = {rows, r};
    r.v = fill_vert(32'h0, 16'h0); r.has_exp = 1;
    r.exp_w.data = pack_vert(r.v); r.exp_w.vld = 1; r.exp_w.fin = 1;
    rows = {rows, r};
    r.has_exp = 0;
    // Triangle crossing the plane, then a two-vertex polygon fully outside, then a long edge.
    r.v = fill_vert(32'hFFF0_0000, 16'h1000); r.last = 0; rows = {rows, r};
    r.v = fill_vert(32'h0010_0000, 16'hF000); rows = {rows, r};
    r.v = fill_vert(32'h0003_0000, 16'h2000); r.last = 1; rows = {rows, r};
    r.v = fill_vert(32'h0001_0000, 16'h0); r.last = 0; rows = {rows, r};
    r.v = fill_vert(32'h0002_0000, 16'h0); r.last = 1; rows = {rows, r};
    r.v = fill_vert(32'h8000_0000, 16'h8000); r.last = 0; rows = {rows, r};
    r.v = fill_vert(32'h7FFF_FFFF, 16'h7FFF); rows = {rows, r};
    r.v = fill_vert(32'hFFFF_FFFF, 16'hFFFF); r.last = 1; rows = {rows, r};
    foreach (rows[i]) begin
      if (rows[i].has_exp) begin
        stop_in();
        while (clip_q.size() != 0) @(negedge clk_i);
        send_vert(rows[i].v, rows[i].last);
        void'(clip_q.pop_back());
        clip_q = {clip_q, rows[i].exp_w};
      end else begin
        send_vert(rows[i].v, rows[i].last);
      end
    end
    set_plane(16'h8000, 16'h7FFF, 16'h8000, 32'h8000_0000);
    for (int i = 0; i < 4; i++) send_vert(rnd_vert(0), i == 3);
    set_plane(16'h7FFF, 16'h8000, 16'h7FFF, 32'h7FFF_FFFF);
    for (int i = 0; i < 3; i++) send_vert(rnd_vert(0), i == 2);
    for (int ph = 0; ph < 5; ph++) begin
      set_plane(16'($urandom()), 16'($urandom()), 16'($urandom()),
                ph == 0 ? 32'h0 : 32'($signed($urandom_range(0, 20 << 16)) - (10 << 16)));
      if (ph == 2) hold_off = 1;
      for (int k = 0; k < 8; k++) begin
        nv = $urandom_range(0, 9) == 0 ? 1 : $urandom_range(2, 6);
        mode = $urandom_range(0, 9) == 0 ? 0 : $urandom_range(1, 2);
        for (int i = 0; i < nv; i++) begin
          v = rnd_vert(mode);
          send_vert(v, i == nv - 1);
        end
      end
    end
    stop_in();
    stim_done = 1;
  end

  initial begin
    @(posedge hold_off);
    @(negedge clk_i);
    m_axis_tready_i <= 0;
    repeat (600) @(negedge clk_i);
    hold_off = 0;
  end

  always @(negedge clk_i) begin
    if (!hold_off) m_axis_tready_i <= ($urandom_range(0, 11) < 8);
  end

  always @(posedge clk_i) begin
    outw_t e;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (clip_q.size() == 0) begin
        $display("%0t: unexpected word data=%h user=%b last=%b", $time,
                 m_axis_tdata_o, m_axis_tuser_o, m_axis_tlast_o);
        errors++;
      end else begin
        e = clip_q.pop_front();
        if (m_axis_tdata_o !== e.data || m_axis_tuser_o !== e.vld
            || m_axis_tlast_o !== e.fin) begin
          $display("%0t: expected data=%h user=%b last=%b", $time,
                   e.data, e.vld, e.fin);
          $display("%0t: actual   data=%h user=%b last=%b", $time,
                   m_axis_tdata_o, m_axis_tuser_o, m_axis_tlast_o);
          errors++;
        end
      end
    end
  end

  initial begin
    wait (stim_done && clip_q.size() == 0);
    repeat (200) @(posedge clk_i);
    if (clip_q.size() == 0 && errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == 400000) begin
      $display("end of test: mismatches");
      $finish;
    end
  end
endmodule

// File: sim.f
rtl/pclip_pkg.sv
rtl/pclip_div.sv
rtl/pclip_lerp.sv
rtl/polygon_plane_clipper_top.sv
tb/tb.sv
